>>> rtl/path_to_line_segment_flattener_macros.svh
// Assertion macros shared by the flattener RTL.
`ifndef PATH_TO_LINE_SEGMENT_FLATTENER_MACROS_SVH
`define PATH_TO_LINE_SEGMENT_FLATTENER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PTLF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTLF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ptlf_pkg.sv
// Package with types, constants and helpers for the path flattener.
package ptlf_pkg;

    localparam int COORD_W = 24;
    localparam int QUAL_W = 7;
    localparam int NUM_W = COORD_W + 10;
    localparam int DEF_MAX_QUALITY = 64;
    localparam logic [QUAL_W-1:0] QUALITY_RESET = QUAL_W'(16);

    localparam logic [2:0] CMD_MOVE = 3'd0;
    localparam logic [2:0] CMD_MOVE_PT = 3'd1;
    localparam logic [2:0] CMD_LINE = 3'd2;
    localparam logic [2:0] CMD_HLINE = 3'd3;
    localparam logic [2:0] CMD_VLINE = 3'd4;
    localparam logic [2:0] CMD_CUBIC = 3'd5;
    localparam logic [2:0] CMD_SMOOTH = 3'd6;
    localparam logic [2:0] CMD_CLOSE = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NUM_W:0] wide_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic relative;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] stop_x;
        logic signed [COORD_W-1:0] stop_y;
        logic last;
    } out_item_t;

    typedef struct packed {
        coord_t a;
        coord_t b;
        logic [QUAL_W-1:0] k;
        logic [QUAL_W-1:0] q;
    } lerp_req_t;

    localparam wide_t SAT_HI = wide_t'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

    function automatic wide_t sx(input coord_t v);
        return wide_t'(v);
    endfunction

    function automatic coord_t sat(input wide_t v);
        coord_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/ptlf_lerp.sv
// Iterative interpolation unit: a + round((b - a) * k / q) with a bit-serial divider.
module ptlf_lerp
    import ptlf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  lerp_req_t req,
    output logic      done,
    output coord_t    result
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {L_IDLE, L_DIV, L_DONE} lstate_t;

    lstate_t state_reg, state_next;
    coord_t a_reg, a_next;
    logic neg_reg, neg_next;
    logic [QUAL_W:0] div_reg, div_next;
    logic [QUAL_W+1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [COORD_W:0] diff;
    logic signed [NUM_W-1:0] prod;
    logic signed [NUM_W-1:0] num;
    logic [QUAL_W+1:0] rem_sh;
    wide_t qs;

    always_comb begin
        diff = {req.b[COORD_W-1], req.b} - {req.a[COORD_W-1], req.a};
        prod = NUM_W'(diff) * NUM_W'($signed({1'b0, req.k}));
        num = (prod <<< 1) + NUM_W'($signed({1'b0, req.q}));
        rem_sh = {rem_reg[QUAL_W:0], quo_reg[NUM_W-1]};
        qs = neg_reg ? -(wide_t'({1'b0, quo_reg}) + wide_t'(rem_reg != '0))
                     : wide_t'({1'b0, quo_reg});

        state_next = state_reg;
        a_next = a_reg;
        neg_next = neg_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    a_next = req.a;
                    neg_next = num[NUM_W-1];
                    quo_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    div_next = {req.q, 1'b0};
                    rem_next = '0;
                    cnt_next = CNT_W'(NUM_W);
                    state_next = L_DIV;
                end
            end
            L_DIV: begin
                if (rem_sh >= {1'b0, div_reg}) begin
                    rem_next = rem_sh - {1'b0, div_reg};
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = L_DONE;
                end
            end
            L_DONE: begin
                state_next = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg <= a_next;
        neg_reg <= neg_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done = (state_reg == L_DONE);
    assign result = sat(qs + sx(a_reg));

endmodule

>>> rtl/path_to_line_segment_flattener.sv
// Top level: path command sequencer driving one shared interpolation unit.
// Line, close and move-extra commands present their segment in the cycle after the transfer.
// A cubic point takes 12 interpolations, run one at a time through the bit-serial divider
// in the shared unit.
// The input is not ready again until the last segment of an item has been taken.
// Reset is synchronous, active low: current, subpath and control points, curve state and quality return to defaults.
`include "path_to_line_segment_flattener_macros.svh"

module path_to_line_segment_flattener
    import ptlf_pkg::*;
#(
    parameter int MAX_QUALITY = DEF_MAX_QUALITY
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [QUAL_W-1:0] cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_POINT, ST_LSTART, ST_LWAIT, ST_EMIT, ST_OWAIT}
        state_t;

    state_t state_reg;
    logic [QUAL_W-1:0] qual_reg;
    logic [QUAL_W-1:0] q_reg;
    logic [QUAL_W-1:0] k_reg;
    coord_t cur_x_reg, cur_y_reg, sub_x_reg, sub_y_reg, pc_x_reg, pc_y_reg;
    logic pwc_reg;
    coord_t p_reg [2][4];
    coord_t t_reg [5];
    coord_t nx_reg, ny_reg, px_reg, py_reg;
    logic axis_reg;
    logic [2:0] li_reg;
    out_item_t out_reg;

    coord_t ox, oy, ax, ay, c1x, c1y, c2x, c2y, hx, vy, rfx, rfy;
    logic [QUAL_W-1:0] q_eff;
    lerp_req_t lreq;
    logic l_start, l_done;
    coord_t l_res;
    logic in_xfer, out_xfer, is_curve;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OWAIT);
    assign m_data = out_reg;
    assign cfg_ready = 1'b1;
    assign in_xfer = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign is_curve = (s_data.cmd == CMD_CUBIC) || (s_data.cmd == CMD_SMOOTH);

    always_comb begin
        ox = s_data.relative ? cur_x_reg : '0;
        oy = s_data.relative ? cur_y_reg : '0;
        ax = sat(sx(ox) + sx(s_data.end_x));
        ay = sat(sx(oy) + sx(s_data.end_y));
        c1x = sat(sx(ox) + sx(s_data.ctrl1_x));
        c1y = sat(sx(oy) + sx(s_data.ctrl1_y));
        c2x = sat(sx(ox) + sx(s_data.ctrl2_x));
        c2y = sat(sx(oy) + sx(s_data.ctrl2_y));
        rfx = sat((sx(cur_x_reg) <<< 1) - sx(pc_x_reg));
        rfy = sat((sx(cur_y_reg) <<< 1) - sx(pc_y_reg));
        hx = cur_x_reg;
        vy = cur_y_reg;
        case (s_data.cmd)
            CMD_MOVE_PT, CMD_LINE: begin
                hx = ax;
                vy = ay;
            end
            CMD_HLINE: hx = ax;
            CMD_VLINE: vy = ay;
            CMD_CLOSE: begin
                hx = sub_x_reg;
                vy = sub_y_reg;
            end
            default: ;
        endcase
        if (qual_reg == '0) begin
            q_eff = QUAL_W'(1);
        end else if (qual_reg > QUAL_W'(MAX_QUALITY)) begin
            q_eff = QUAL_W'(MAX_QUALITY);
        end else begin
            q_eff = qual_reg;
        end
    end

    always_comb begin
        lreq.k = k_reg;
        lreq.q = q_reg;
        case (li_reg)
            3'd0: begin
                lreq.a = p_reg[axis_reg][0];
                lreq.b = p_reg[axis_reg][1];
            end
            3'd1: begin
                lreq.a = p_reg[axis_reg][1];
                lreq.b = p_reg[axis_reg][2];
            end
            3'd2: begin
                lreq.a = p_reg[axis_reg][2];
                lreq.b = p_reg[axis_reg][3];
            end
            3'd3: begin
                lreq.a = t_reg[0];
                lreq.b = t_reg[1];
            end
            3'd4: begin
                lreq.a = t_reg[1];
                lreq.b = t_reg[2];
            end
            default: begin
                lreq.a = t_reg[3];
                lreq.b = t_reg[4];
            end
        endcase
    end

    assign l_start = (state_reg == ST_LSTART);

    ptlf_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (l_start),
        .req     (lreq),
        .done    (l_done),
        .result  (l_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            qual_reg <= QUALITY_RESET;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            sub_x_reg <= '0;
            sub_y_reg <= '0;
            pc_x_reg <= '0;
            pc_y_reg <= '0;
            pwc_reg <= 1'b0;
            k_reg <= '0;
            q_reg <= QUAL_W'(1);
            axis_reg <= 1'b0;
            li_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                qual_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (is_curve) begin
                            p_reg[0][0] <= cur_x_reg;
                            p_reg[1][0] <= cur_y_reg;
                            if (s_data.cmd == CMD_CUBIC) begin
                                p_reg[0][1] <= c1x;
                                p_reg[1][1] <= c1y;
                            end else if (pwc_reg) begin
                                p_reg[0][1] <= rfx;
                                p_reg[1][1] <= rfy;
                            end else begin
                                p_reg[0][1] <= cur_x_reg;
                                p_reg[1][1] <= cur_y_reg;
                            end
                            p_reg[0][2] <= c2x;
                            p_reg[1][2] <= c2y;
                            p_reg[0][3] <= ax;
                            p_reg[1][3] <= ay;
                            px_reg <= cur_x_reg;
                            py_reg <= cur_y_reg;
                            q_reg <= q_eff;
                            k_reg <= QUAL_W'(1);
                            state_reg <= ST_POINT;
                        end else begin
                            pwc_reg <= 1'b0;
                            if (s_data.cmd == CMD_MOVE) begin
                                cur_x_reg <= ax;
                                cur_y_reg <= ay;
                                sub_x_reg <= ax;
                                sub_y_reg <= ay;
                            end else begin
                                out_reg <= '{start_x: cur_x_reg, start_y: cur_y_reg,
                                             stop_x: hx, stop_y: vy, last: 1'b1};
                                cur_x_reg <= hx;
                                cur_y_reg <= vy;
                                state_reg <= ST_OWAIT;
                            end
                        end
                    end
                end
                ST_POINT: begin
                    if (k_reg == q_reg) begin
                        nx_reg <= p_reg[0][3];
                        ny_reg <= p_reg[1][3];
                        state_reg <= ST_EMIT;
                    end else begin
                        axis_reg <= 1'b0;
                        li_reg <= '0;
                        state_reg <= ST_LSTART;
                    end
                end
                ST_LSTART: begin
                    state_reg <= ST_LWAIT;
                end
                ST_LWAIT: begin
                    if (l_done) begin
                        if (li_reg != 3'd5) begin
                            t_reg[li_reg] <= l_res;
                            li_reg <= li_reg + 3'd1;
                            state_reg <= ST_LSTART;
                        end else if (!axis_reg) begin
                            nx_reg <= l_res;
                            axis_reg <= 1'b1;
                            li_reg <= '0;
                            state_reg <= ST_LSTART;
                        end else begin
                            ny_reg <= l_res;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    out_reg <= '{start_x: px_reg, start_y: py_reg, stop_x: nx_reg,
                                 stop_y: ny_reg, last: (k_reg == q_reg)};
                    px_reg <= nx_reg;
                    py_reg <= ny_reg;
                    state_reg <= ST_OWAIT;
                end
                ST_OWAIT: begin
                    if (out_xfer) begin
                        if (out_reg.last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg <= k_reg + QUAL_W'(1);
                            state_reg <= ST_POINT;
                        end
                        if (out_reg.last && (k_reg != '0) && (k_reg == q_reg)) begin
                            cur_x_reg <= p_reg[0][3];
                            cur_y_reg <= p_reg[1][3];
                            pc_x_reg <= p_reg[0][2];
                            pc_y_reg <= p_reg[1][2];
                            pwc_reg <= 1'b1;
                            k_reg <= '0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `PTLF_ASSERT_IMP(a_ready_excl, s_ready, !m_valid, "input ready while a segment waits")
    `PTLF_ASSERT_NXT(a_last_frees, out_xfer && m_data.last, s_ready,
        "block not ready after the last segment of an item")
    `PTLF_ASSERT_IMP(a_k_range, state_reg == ST_POINT,
        (k_reg >= QUAL_W'(1)) && (k_reg <= q_reg), "curve step outside 1..quality")

endmodule
